@@ rtl/core/wrts_pkg.sv @@
package wrts_pkg;

   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [1:0] REASON_NONE      = 2'd0;
   localparam logic [1:0] REASON_IMMINENT  = 2'd1;
   localparam logic [1:0] REASON_SUGGESTED = 2'd2;
   localparam logic [1:0] REASON_LOW_RSSI  = 2'd3;

   localparam logic CSR_RSSI_THRESHOLD    = 1'b0;
   localparam logic CSR_HYSTERESIS_MARGIN = 1'b1;

   localparam logic signed [7:0] RSSI_THRESHOLD_RESET    = -8'sd75;
   localparam logic [7:0]        HYSTERESIS_MARGIN_RESET = 8'd8;

   typedef struct packed {
      logic signed [7:0] cur_rssi;
      logic              present;
      logic              imminent;
      logic              has_pref;
      logic [47:0]       pref_addr;
      logic              best_found;
      logic [47:0]       best_addr;
      logic signed [7:0] best_strength;
      logic [7:0]        best_chan;
      logic              pref_found;
      logic signed [7:0] pref_strength;
      logic [7:0]        pref_chan;
   } decision_type;

   typedef struct packed {
      logic         valid;
      decision_type data;
   } queue_head_type;

endpackage

@@ rtl/core/wrts_front.sv @@
module wrts_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [47:0]            link_addr,
   input  logic signed [7:0]      current_rssi,
   input  logic                   btm_present,
   input  logic                   btm_imminent,
   input  logic                   btm_has_preferred,
   input  logic [47:0]            favoured_addr,
   input  logic                   nb_valid,
   input  logic [47:0]            nb_bssid,
   input  logic signed [7:0]      nb_rssi,
   input  logic [7:0]             nb_channel,
   input  logic                   last,
   output logic                   decision_push,
   output wrts_pkg::decision_type decision
);

   logic              best_found_ff, best_found_in;
   logic [47:0]       best_addr_ff, best_addr_in;
   logic signed [7:0] best_strength_ff, best_strength_in;
   logic [7:0]        best_chan_ff, best_chan_in;
   logic              pref_found_ff, pref_found_in;
   logic signed [7:0] pref_strength_ff, pref_strength_in;
   logic [7:0]        pref_chan_ff, pref_chan_in;
   logic              take_best;
   logic              take_pref;

   always_comb begin
      take_best = nb_valid && (nb_bssid != link_addr) &&
                  (!best_found_ff || (nb_rssi > best_strength_ff));
      take_pref = nb_valid && !pref_found_ff && (nb_bssid == favoured_addr);

      decision.cur_rssi      = current_rssi;
      decision.present       = btm_present;
      decision.imminent      = btm_imminent;
      decision.has_pref      = btm_has_preferred;
      decision.pref_addr     = favoured_addr;
      decision.best_found    = best_found_ff | take_best;
      decision.best_addr     = take_best ? nb_bssid : best_addr_ff;
      decision.best_strength = take_best ? nb_rssi : best_strength_ff;
      decision.best_chan     = take_best ? nb_channel : best_chan_ff;
      decision.pref_found    = pref_found_ff | take_pref;
      decision.pref_strength = take_pref ? nb_rssi : pref_strength_ff;
      decision.pref_chan     = take_pref ? nb_channel : pref_chan_ff;

      decision_push = accept && last;

      best_found_in    = best_found_ff;
      best_addr_in     = best_addr_ff;
      best_strength_in = best_strength_ff;
      best_chan_in     = best_chan_ff;
      pref_found_in    = pref_found_ff;
      pref_strength_in = pref_strength_ff;
      pref_chan_in     = pref_chan_ff;
      if (accept) begin
         best_addr_in     = decision.best_addr;
         best_strength_in = decision.best_strength;
         best_chan_in     = decision.best_chan;
         pref_strength_in = decision.pref_strength;
         pref_chan_in     = decision.pref_chan;
         if (last) begin
            best_found_in = 1'b0;
            pref_found_in = 1'b0;
         end else begin
            best_found_in = decision.best_found;
            pref_found_in = decision.pref_found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
         pref_found_ff <= 1'b0;
      end else begin
         best_found_ff <= best_found_in;
         pref_found_ff <= pref_found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_addr_ff     <= best_addr_in;
      best_strength_ff <= best_strength_in;
      best_chan_ff     <= best_chan_in;
      pref_strength_ff <= pref_strength_in;
      pref_chan_ff     <= pref_chan_in;
   end

endmodule

@@ rtl/core/wrts_queue.sv @@
module wrts_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  wrts_pkg::decision_type   push_data,
   output logic                     full,
   input  logic                     pop,
   output wrts_pkg::queue_head_type head
);

   wrts_pkg::decision_type mem [wrts_pkg::QueueDepth];

   logic [wrts_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [wrts_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [wrts_pkg::QueueCountWidth-1:0] count_ff, count_in;
   logic                                 do_push;
   logic                                 do_pop;

   function automatic logic [wrts_pkg::QueuePtrWidth-1:0] next_ptr(
      input logic [wrts_pkg::QueuePtrWidth-1:0] ptr
   );
      logic [wrts_pkg::QueuePtrWidth-1:0] result;
      if (ptr == wrts_pkg::QueuePtrWidth'(wrts_pkg::QueueDepth - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

   always_comb begin
      full       = (count_ff == wrts_pkg::QueueCountWidth'(wrts_pkg::QueueDepth));
      head.valid = (count_ff != '0);
      head.data  = mem[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head.valid;
      wr_ptr_in  = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/wrts_back.sv @@
module wrts_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [7:0]               csr_write_data,
   input  wrts_pkg::queue_head_type head,
   output logic                     head_pop,
   output logic                     empty,
   input  logic                     pop,
   output logic                     roam,
   output logic [47:0]              dest_addr,
   output logic [7:0]               dest_chan,
   output logic [1:0]               reason
);

   logic signed [7:0] rssi_threshold_ff, rssi_threshold_in;
   logic [7:0]        hysteresis_margin_ff, hysteresis_margin_in;
   logic              out_valid_ff, out_valid_in;
   logic              roam_ff, roam_in;
   logic [47:0]       dest_addr_ff, dest_addr_in;
   logic [7:0]        dest_chan_ff, dest_chan_in;
   logic [1:0]        reason_ff, reason_in;
   logic signed [9:0] gap;
   logic              load;

   wrts_pkg::decision_type d;

   always_comb begin
      rssi_threshold_in    = rssi_threshold_ff;
      hysteresis_margin_in = hysteresis_margin_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            wrts_pkg::CSR_RSSI_THRESHOLD:    rssi_threshold_in = csr_write_data;
            wrts_pkg::CSR_HYSTERESIS_MARGIN: hysteresis_margin_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      d    = head.data;
      gap  = 10'(d.best_strength) - 10'(d.cur_rssi);
      load = head.valid && (!out_valid_ff || pop);
      head_pop = load;

      roam_in      = 1'b0;
      dest_addr_in = '0;
      dest_chan_in = '0;
      reason_in    = wrts_pkg::REASON_NONE;
      priority if (d.present && d.imminent) begin
         if (d.has_pref && d.pref_found) begin
            roam_in      = 1'b1;
            dest_addr_in = d.pref_addr;
            dest_chan_in = d.pref_chan;
            reason_in    = wrts_pkg::REASON_IMMINENT;
         end else if (d.best_found) begin
            roam_in      = 1'b1;
            dest_addr_in = d.best_addr;
            dest_chan_in = d.best_chan;
            reason_in    = wrts_pkg::REASON_IMMINENT;
         end
      end else if (d.present && d.has_pref && d.pref_found &&
                   (d.pref_strength >= d.cur_rssi)) begin
         roam_in      = 1'b1;
         dest_addr_in = d.pref_addr;
         dest_chan_in = d.pref_chan;
         reason_in    = wrts_pkg::REASON_SUGGESTED;
      end else if (d.best_found && (d.cur_rssi <= rssi_threshold_ff) &&
                   (gap >= $signed({2'b00, hysteresis_margin_ff}))) begin
         roam_in      = 1'b1;
         dest_addr_in = d.best_addr;
         dest_chan_in = d.best_chan;
         reason_in    = wrts_pkg::REASON_LOW_RSSI;
      end else begin
         reason_in    = wrts_pkg::REASON_NONE;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rssi_threshold_ff    <= wrts_pkg::RSSI_THRESHOLD_RESET;
         hysteresis_margin_ff <= wrts_pkg::HYSTERESIS_MARGIN_RESET;
         out_valid_ff         <= 1'b0;
      end else begin
         rssi_threshold_ff    <= rssi_threshold_in;
         hysteresis_margin_ff <= hysteresis_margin_in;
         out_valid_ff         <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         roam_ff      <= roam_in;
         dest_addr_ff <= dest_addr_in;
         dest_chan_ff <= dest_chan_in;
         reason_ff    <= reason_in;
      end
   end

   assign empty     = !out_valid_ff;
   assign roam      = roam_ff;
   assign dest_addr = dest_addr_ff;
   assign dest_chan = dest_chan_ff;
   assign reason    = reason_ff;

endmodule

@@ rtl/core/wifi_roam_target_select.sv @@
// One neighbour transaction is accepted per cycle while full is low.
// The decision for a run is queued when its last transaction is accepted, then loaded into
// the result-port register when the result side is draining; one decision per cycle at most.
// The rate is set by the front's combinational compare against the running best and preferred.
// Reset is synchronous and active high: it clears the running state, empties the queue
// and output register, and restores the threshold to -75 dBm and the margin to 8 dB.
module wifi_roam_target_select (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [47:0]       req_link_addr,
   input  logic signed [7:0] req_current_rssi,
   input  logic              req_btm_present,
   input  logic              req_btm_imminent,
   input  logic              req_btm_has_preferred,
   input  logic [47:0]       req_favoured_addr,
   input  logic              req_nb_valid,
   input  logic [47:0]       req_nb_bssid,
   input  logic signed [7:0] req_nb_rssi,
   input  logic [7:0]        req_nb_channel,
   input  logic              req_last,
   output logic              empty,
   input  logic              pop,
   output logic              rsp_roam,
   output logic [47:0]       rsp_dest_addr,
   output logic [7:0]        rsp_dest_chan,
   output logic [1:0]        rsp_reason,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [7:0]        csr_write_data
);

   wrts_pkg::decision_type   decision;
   wrts_pkg::queue_head_type head;
   logic                     accept;
   logic                     decision_push;
   logic                     head_pop;

   assign accept = push && !full;

   wrts_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .link_addr         (req_link_addr),
      .current_rssi      (req_current_rssi),
      .btm_present       (req_btm_present),
      .btm_imminent      (req_btm_imminent),
      .btm_has_preferred (req_btm_has_preferred),
      .favoured_addr     (req_favoured_addr),
      .nb_valid          (req_nb_valid),
      .nb_bssid          (req_nb_bssid),
      .nb_rssi           (req_nb_rssi),
      .nb_channel        (req_nb_channel),
      .last              (req_last),
      .decision_push     (decision_push),
      .decision          (decision)
   );

   wrts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (decision_push),
      .push_data (decision),
      .full      (full),
      .pop       (head_pop),
      .head      (head)
   );

   wrts_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .head             (head),
      .head_pop         (head_pop),
      .empty            (empty),
      .pop              (pop),
      .roam             (rsp_roam),
      .dest_addr        (rsp_dest_addr),
      .dest_chan        (rsp_dest_chan),
      .reason           (rsp_reason)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_roam == (rsp_reason != wrts_pkg::REASON_NONE)))
      else $error("Roam flag disagrees with the reason code.");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_roam) |-> (rsp_dest_addr == '0 && rsp_dest_chan == '0))
      else $error("A stay decision carries a non-zero target.");

   assert property (@(posedge clock) disable iff (reset)
      (full && !head_pop) |=> full)
      else $error("The decision queue lost an entry while stalled.");
`endif

endmodule

@@ bench/roam_bench_pkg.sv @@
package roam_bench_pkg;

   typedef struct packed {
      logic [47:0]       link_addr;
      logic signed [7:0] current_rssi;
      logic              btm_present;
      logic              btm_imminent;
      logic              btm_has_preferred;
      logic [47:0]       favoured_addr;
      logic              nb_valid;
      logic [47:0]       nb_bssid;
      logic signed [7:0] nb_rssi;
      logic [7:0]        nb_channel;
      logic              last;
   } neighbour_req_type;

   typedef struct packed {
      logic        roam;
      logic [47:0] dest_addr;
      logic [7:0]  dest_chan;
      logic [1:0]  reason;
   } roam_decision_type;

   class roam_scoreboard;
      logic signed [7:0] rssi_threshold;
      logic [7:0]        hysteresis_margin;
      logic              best_found;
      logic [47:0]       best_bssid;
      logic signed [7:0] best_rssi;
      logic [7:0]        best_channel;
      logic              pref_found;
      logic signed [7:0] pref_rssi;
      logic [7:0]        pref_channel;
      roam_decision_type awaited_decisions[$];
      int                errors;
      int                decisions_checked;
      int                reason_count[4];

      function new();
         rssi_threshold = wrts_pkg::RSSI_THRESHOLD_RESET;
         hysteresis_margin = wrts_pkg::HYSTERESIS_MARGIN_RESET;
         errors = 0;
         decisions_checked = 0;
         foreach (reason_count[i]) reason_count[i] = 0;
         clear_run();
      endfunction

      function void clear_run();
         best_found = 1'b0;
         best_bssid = '0;
         best_rssi = '0;
         best_channel = '0;
         pref_found = 1'b0;
         pref_rssi = '0;
         pref_channel = '0;
      endfunction

      function void write_register(logic index, logic [7:0] data);
         if (index == wrts_pkg::CSR_RSSI_THRESHOLD) begin
            rssi_threshold = data;
         end else begin
            hysteresis_margin = data;
         end
      endfunction

      function void note_request(neighbour_req_type r);
         roam_decision_type d;
         int cur;
         if (r.nb_valid) begin
            if (r.nb_bssid != r.link_addr &&
                (!best_found || int'(r.nb_rssi) > int'(best_rssi))) begin
               best_found = 1'b1;
               best_bssid = r.nb_bssid;
               best_rssi = r.nb_rssi;
               best_channel = r.nb_channel;
            end
            if (!pref_found && r.nb_bssid == r.favoured_addr) begin
               pref_found = 1'b1;
               pref_rssi = r.nb_rssi;
               pref_channel = r.nb_channel;
            end
         end
         if (r.last) begin
            d = '0;
            d.reason = wrts_pkg::REASON_NONE;
            cur = int'(r.current_rssi);
            if (r.btm_present && r.btm_imminent) begin
               if (r.btm_has_preferred && pref_found) begin
                  d = '{1'b1, r.favoured_addr, pref_channel, wrts_pkg::REASON_IMMINENT};
               end else if (best_found) begin
                  d = '{1'b1, best_bssid, best_channel, wrts_pkg::REASON_IMMINENT};
               end
            end else if (r.btm_present && r.btm_has_preferred && pref_found &&
                         int'(pref_rssi) >= cur) begin
               d = '{1'b1, r.favoured_addr, pref_channel, wrts_pkg::REASON_SUGGESTED};
            end else if (best_found && cur <= int'(rssi_threshold) &&
                         int'(best_rssi) >= cur + int'(hysteresis_margin)) begin
               d = '{1'b1, best_bssid, best_channel, wrts_pkg::REASON_LOW_RSSI};
            end
            awaited_decisions.push_back(d);
            clear_run();
         end
      endfunction

      function void check_decision(roam_decision_type got);
         roam_decision_type want;
         if (awaited_decisions.size() == 0) begin
            $error("unexpected decision: roam %0b target %h channel %0d reason %0d",
                   got.roam, got.dest_addr, got.dest_chan, got.reason);
            errors++;
            return;
         end
         want = awaited_decisions.pop_front();
         decisions_checked++;
         reason_count[want.reason]++;
         if (got.roam !== want.roam) begin
            $error("roam: expected %0b, got %0b", want.roam, got.roam);
            errors++;
         end
         if (got.dest_addr !== want.dest_addr) begin
            $error("dest_addr: expected %h, got %h", want.dest_addr, got.dest_addr);
            errors++;
         end
         if (got.dest_chan !== want.dest_chan) begin
            $error("dest_chan: expected %0d, got %0d", want.dest_chan, got.dest_chan);
            errors++;
         end
         if (got.reason !== want.reason) begin
            $error("reason: expected %0d, got %0d", want.reason, got.reason);
            errors++;
         end
      endfunction

      function int pending();
         return awaited_decisions.size();
      endfunction
   endclass

endpackage

@@ bench/wifi_roam_target_select_test.sv @@
module wifi_roam_target_select_test;

   localparam int PhaseCount = 8;
   localparam int ItemsPerPhase = 230;
   localparam int HoldCycles = 120;
   localparam int SettleCycles = 6;
   localparam int WatchdogLimit = 2000;

   localparam logic [2:0] BTM_NONE          = 3'b000;
   localparam logic [2:0] BTM_IMMINENT      = 3'b110;
   localparam logic [2:0] BTM_IMMINENT_PREF = 3'b111;
   localparam logic [2:0] BTM_SUGGESTED     = 3'b101;
   localparam logic [2:0] BTM_NOT_SENT      = 3'b011;

   localparam logic [47:0] ZeroAp  = 48'h0000_0000_0000;
   localparam logic [47:0] OnesAp  = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] CurAp   = 48'h0A0B_0C0D_0E0F;
   localparam logic [47:0] PrefAp  = 48'h021A_2B3C_4D5E;
   localparam logic [47:0] OtherAp = 48'h0211_2233_4455;
   localparam logic [47:0] SpareAp = 48'h06A0_B0C0_D0E0;
   localparam logic [47:0] ThirdAp = 48'h0E55_6677_8899;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_style_type;

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   logic [47:0]       req_link_addr;
   logic signed [7:0] req_current_rssi;
   logic              req_btm_present;
   logic              req_btm_imminent;
   logic              req_btm_has_preferred;
   logic [47:0]       req_favoured_addr;
   logic              req_nb_valid;
   logic [47:0]       req_nb_bssid;
   logic signed [7:0] req_nb_rssi;
   logic [7:0]        req_nb_channel;
   logic              req_last;
   logic              empty;
   logic              pop;
   logic              rsp_roam;
   logic [47:0]       rsp_dest_addr;
   logic [7:0]        rsp_dest_chan;
   logic [1:0]        rsp_reason;
   logic              csr_write_enable;
   logic              csr_index;
   logic [7:0]        csr_write_data;

   roam_bench_pkg::roam_scoreboard sb;
   int             items_sent;
   int             burst_left;
   int             hold_requests;
   int             holds_done;
   int             idle_cycles;
   int             rx_tick;
   rx_style_type   rx_style;
   logic           sender_gaps;
   logic           run_open;

   wifi_roam_target_select i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_link_addr         (req_link_addr),
      .req_current_rssi      (req_current_rssi),
      .req_btm_present       (req_btm_present),
      .req_btm_imminent      (req_btm_imminent),
      .req_btm_has_preferred (req_btm_has_preferred),
      .req_favoured_addr     (req_favoured_addr),
      .req_nb_valid          (req_nb_valid),
      .req_nb_bssid          (req_nb_bssid),
      .req_nb_rssi           (req_nb_rssi),
      .req_nb_channel        (req_nb_channel),
      .req_last              (req_last),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_roam              (rsp_roam),
      .rsp_dest_addr         (rsp_dest_addr),
      .rsp_dest_chan         (rsp_dest_chan),
      .rsp_reason            (rsp_reason),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         sb.check_decision({rsp_roam, rsp_dest_addr, rsp_dest_chan, rsp_reason});
      end
   end

   // The result side follows a randomly redrawn stall style of its own, and
   // holds off completely for a long stretch whenever one is requested.
   initial begin
      pop = 1'b0;
      holds_done = 0;
      rx_tick = 0;
      rx_style = RX_ALWAYS;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            pop = 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         rx_tick++;
         if (rx_tick % 64 == 0) rx_style = rx_style_type'($urandom_range(0, 3));
         case (rx_style)
            RX_ALWAYS: pop = 1'b1;
            RX_COIN: pop = 1'($urandom_range(0, 1));
            RX_PATTERN: pop = (rx_tick % 5) < 2;
            default: pop = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic [47:0] rand_addr();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0];
   endfunction

   function automatic logic signed [7:0] low_biased_rssi();
      int v;
      if ($urandom_range(0, 1) == 0) begin
         v = int'($urandom_range(0, 78)) - 128;
      end else begin
         v = int'($urandom_range(0, 255)) - 128;
      end
      return 8'(v);
   endfunction

   function automatic roam_bench_pkg::neighbour_req_type neighbour(
      logic [47:0] cur, logic signed [7:0] cur_rssi, logic [2:0] btm, logic [47:0] pref,
      logic valid, logic [47:0] nb, logic signed [7:0] nb_rssi, logic [7:0] chan,
      logic last);
      return '{cur, cur_rssi, btm[2], btm[1], btm[0], pref, valid, nb, nb_rssi, chan, last};
   endfunction

   task automatic send_request(input roam_bench_pkg::neighbour_req_type r);
      int   gap;
      logic taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = sender_gaps ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_link_addr = r.link_addr;
      req_current_rssi = r.current_rssi;
      req_btm_present = r.btm_present;
      req_btm_imminent = r.btm_imminent;
      req_btm_has_preferred = r.btm_has_preferred;
      req_favoured_addr = r.favoured_addr;
      req_nb_valid = r.nb_valid;
      req_nb_bssid = r.nb_bssid;
      req_nb_rssi = r.nb_rssi;
      req_nb_channel = r.nb_channel;
      req_last = r.last;
      push = 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         if (!full) begin
            taken = 1'b1;
            sb.note_request(r);
         end
         @(negedge clock);
      end
      items_sent++;
      run_open = !r.last;
   endtask

   task automatic send_noise(input logic close_run);
      logic [191:0]                      bits;
      roam_bench_pkg::neighbour_req_type r;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = bits[$bits(roam_bench_pkg::neighbour_req_type)-1:0];
      if (close_run) r.last = 1'b1;
      send_request(r);
   endtask

   // A well-formed run: context mostly shared, neighbours drawn mostly from a small
   // set of addresses so that current and preferred matches are frequent.
   task automatic send_random_run(input int max_len);
      roam_bench_pkg::neighbour_req_type ctx;
      roam_bench_pkg::neighbour_req_type r;
      logic [47:0]                       pool[3];
      int                                len;
      int                                pick;
      foreach (pool[i]) pool[i] = rand_addr();
      ctx = '0;
      ctx.link_addr = rand_addr();
      ctx.current_rssi = low_biased_rssi();
      {ctx.btm_present, ctx.btm_imminent, ctx.btm_has_preferred} = 3'($urandom);
      ctx.favoured_addr = ($urandom_range(0, 3) == 0) ? ctx.link_addr : rand_addr();
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
               0: ctx.link_addr = pool[$urandom_range(0, 2)];
               1: ctx.favoured_addr = pool[$urandom_range(0, 2)];
               default: begin
                  {ctx.btm_present, ctx.btm_imminent, ctx.btm_has_preferred} = 3'($urandom);
                  ctx.current_rssi = 8'($urandom);
               end
            endcase
         end
         r = ctx;
         r.nb_valid = ($urandom_range(0, 9) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            r.nb_bssid = ctx.link_addr;
         end else if (pick < 4) begin
            r.nb_bssid = ctx.favoured_addr;
         end else if (pick < 8) begin
            r.nb_bssid = pool[pick % 3];
         end else begin
            r.nb_bssid = rand_addr();
         end
         r.nb_rssi = 8'($urandom);
         r.nb_channel = 8'($urandom);
         r.last = (i == len - 1);
         send_request(r);
      end
   endtask

   task automatic settle();
      push = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [7:0] data);
      csr_index = index;
      csr_write_data = data;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.write_register(index, data);
   endtask

   task automatic send_directed();
      // Empty run.
      send_request(neighbour(CurAp, -8'sd80, BTM_NONE, PrefAp, 1'b0, SpareAp, 8'sd0, 8'd0, 1'b1));
      // Extreme values; a neighbour equal to the current AP is never the best.
      send_request(neighbour(ZeroAp, -8'sd128, BTM_NONE, PrefAp, 1'b1, OnesAp, 8'sd127,
                             8'd255, 1'b0));
      send_request(neighbour(ZeroAp, -8'sd128, BTM_NONE, PrefAp, 1'b1, ZeroAp, 8'sd127,
                             8'd9, 1'b1));
      // Equal strengths keep the first, and an invalid neighbour is ignored.
      send_request(neighbour(CurAp, -8'sd80, BTM_NONE, PrefAp, 1'b1, OtherAp, -8'sd60,
                             8'd1, 1'b0));
      send_request(neighbour(CurAp, -8'sd80, BTM_NONE, PrefAp, 1'b1, SpareAp, -8'sd60,
                             8'd2, 1'b0));
      send_request(neighbour(CurAp, -8'sd80, BTM_NONE, PrefAp, 1'b0, ThirdAp, 8'sd100,
                             8'd5, 1'b0));
      send_request(neighbour(CurAp, -8'sd80, BTM_NONE, PrefAp, 1'b1, ThirdAp, -8'sd70,
                             8'd3, 1'b1));
      // Imminent request: preferred first, else strongest, else stay.
      send_request(neighbour(CurAp, -8'sd60, BTM_IMMINENT_PREF, PrefAp, 1'b1, PrefAp,
                             -8'sd90, 8'd6, 1'b0));
      send_request(neighbour(CurAp, -8'sd60, BTM_IMMINENT_PREF, PrefAp, 1'b1, OtherAp,
                             -8'sd40, 8'd11, 1'b1));
      send_request(neighbour(CurAp, -8'sd60, BTM_IMMINENT, PrefAp, 1'b1, OtherAp, -8'sd50,
                             8'd36, 1'b1));
      send_request(neighbour(CurAp, -8'sd60, BTM_IMMINENT_PREF, PrefAp, 1'b1, CurAp,
                             -8'sd30, 8'd1, 1'b1));
      // Suggested request: taken when not weaker, otherwise fall through to low signal.
      send_request(neighbour(CurAp, -8'sd70, BTM_SUGGESTED, PrefAp, 1'b1, PrefAp, -8'sd70,
                             8'd44, 1'b1));
      send_request(neighbour(CurAp, -8'sd80, BTM_SUGGESTED, PrefAp, 1'b1, PrefAp, -8'sd85,
                             8'd1, 1'b0));
      send_request(neighbour(CurAp, -8'sd80, BTM_SUGGESTED, PrefAp, 1'b1, OtherAp, -8'sd60,
                             8'd149, 1'b1));
      // Preferred AP that is also the current AP.
      send_request(neighbour(CurAp, 8'sd0, BTM_SUGGESTED, CurAp, 1'b1, CurAp, 8'sd10,
                             8'd7, 1'b1));
      // Context that changes inside a run.
      send_request(neighbour(CurAp, -8'sd20, BTM_NONE, OtherAp, 1'b1, OtherAp, -8'sd50,
                             8'd3, 1'b0));
      send_request(neighbour(OtherAp, 8'sd127, BTM_IMMINENT_PREF, CurAp, 1'b1, CurAp,
                             -8'sd55, 8'd4, 1'b1));
      // Imminent flag without a request present.
      send_request(neighbour(CurAp, -8'sd60, BTM_NOT_SENT, PrefAp, 1'b1, PrefAp, 8'sd0,
                             8'd13, 1'b1));
      // Margin and threshold boundaries.
      send_request(neighbour(CurAp, -8'sd83, BTM_NONE, PrefAp, 1'b1, OtherAp, -8'sd75,
                             8'd20, 1'b1));
      send_request(neighbour(CurAp, -8'sd83, BTM_NONE, PrefAp, 1'b1, OtherAp, -8'sd76,
                             8'd21, 1'b1));
      send_request(neighbour(CurAp, -8'sd75, BTM_NONE, PrefAp, 1'b1, OtherAp, -8'sd67,
                             8'd22, 1'b1));
      send_request(neighbour(CurAp, -8'sd74, BTM_NONE, PrefAp, 1'b1, OtherAp, -8'sd20,
                             8'd23, 1'b1));
   endtask

   initial begin
      int   goal;
      int   max_len;
      logic pressure;
      sb = new();
      reset = 1'b1;
      push = 1'b0;
      req_link_addr = '0;
      req_current_rssi = '0;
      req_btm_present = 1'b0;
      req_btm_imminent = 1'b0;
      req_btm_has_preferred = 1'b0;
      req_favoured_addr = '0;
      req_nb_valid = 1'b0;
      req_nb_bssid = '0;
      req_nb_rssi = '0;
      req_nb_channel = '0;
      req_last = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = wrts_pkg::CSR_RSSI_THRESHOLD;
      csr_write_data = '0;
      items_sent = 0;
      burst_left = 0;
      hold_requests = 0;
      sender_gaps = 1'b1;
      run_open = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_directed();
      for (int phase = 0; phase < PhaseCount; phase++) begin
         settle();
         sender_gaps = 1'b1;
         max_len = 6;
         pressure = 1'b0;
         case (phase)
            1: begin
               write_csr(wrts_pkg::CSR_RSSI_THRESHOLD, 8'sd127);
               write_csr(wrts_pkg::CSR_HYSTERESIS_MARGIN, 8'd0);
            end
            2: begin
               write_csr(wrts_pkg::CSR_RSSI_THRESHOLD, 8'h80);
               write_csr(wrts_pkg::CSR_HYSTERESIS_MARGIN, 8'd255);
               pressure = 1'b1;
            end
            3: begin
               write_csr(wrts_pkg::CSR_RSSI_THRESHOLD, 8'($urandom));
               write_csr(wrts_pkg::CSR_HYSTERESIS_MARGIN, 8'($urandom_range(0, 40)));
               sender_gaps = 1'b0;
            end
            4: begin
               write_csr(wrts_pkg::CSR_RSSI_THRESHOLD, 8'sd127);
               write_csr(wrts_pkg::CSR_HYSTERESIS_MARGIN, 8'd255);
            end
            5: begin
               write_csr(wrts_pkg::CSR_RSSI_THRESHOLD, 8'h80);
               write_csr(wrts_pkg::CSR_HYSTERESIS_MARGIN, 8'd0);
               pressure = 1'b1;
            end
            6: begin
               write_csr(wrts_pkg::CSR_RSSI_THRESHOLD, 8'($urandom));
               write_csr(wrts_pkg::CSR_HYSTERESIS_MARGIN, 8'($urandom));
            end
            7: begin
               write_csr(wrts_pkg::CSR_RSSI_THRESHOLD, wrts_pkg::RSSI_THRESHOLD_RESET);
               write_csr(wrts_pkg::CSR_HYSTERESIS_MARGIN, wrts_pkg::HYSTERESIS_MARGIN_RESET);
            end
            default: ;
         endcase
         // Short runs back to back while the result side holds off fill the block up.
         if (pressure) begin
            sender_gaps = 1'b0;
            max_len = 2;
            hold_requests++;
         end
         goal = items_sent + ItemsPerPhase;
         while (items_sent < goal) begin
            if ($urandom_range(0, 7) == 0) begin
               send_noise(1'b0);
            end else begin
               send_random_run(max_len);
            end
         end
         if (run_open) send_noise(1'b1);
      end
      settle();

      $display("Sent %0d transactions over %0d register settings with gaps and long stalls;",
               items_sent, PhaseCount);
      $display("%0d decisions: %0d stay, %0d imminent, %0d suggested, %0d low signal.",
               sb.decisions_checked, sb.reason_count[wrts_pkg::REASON_NONE],
               sb.reason_count[wrts_pkg::REASON_IMMINENT],
               sb.reason_count[wrts_pkg::REASON_SUGGESTED],
               sb.reason_count[wrts_pkg::REASON_LOW_RSSI]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
